// File: rtl/qpr_pkg.sv
package qpr_pkg;

  localparam int POINT_W   = 24;
  localparam int QUAT_W    = 16;
  localparam int QUAT_FRAC = QUAT_W - 2;
  localparam int ROT_SHIFT = 2 * QUAT_FRAC;

  // q*p products and sums, then (q*p)*conj(q) products and sums
  localparam int PROD1_W = POINT_W + QUAT_W;
  localparam int T_W     = PROD1_W + 2;
  localparam int PROD2_W = T_W + QUAT_W;
  localparam int U_W     = PROD2_W + 2;
  localparam int RND_W   = U_W - ROT_SHIFT;

  typedef logic signed [POINT_W-1:0] point_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [PROD1_W-1:0] prod1_t;
  typedef logic signed [T_W-1:0]     tsum_t;
  typedef logic signed [PROD2_W-1:0] prod2_t;
  typedef logic signed [U_W-1:0]     usum_t;
  typedef logic signed [RND_W-1:0]   rnd_t;

  localparam point_t POINT_MAX = {1'b0, {(POINT_W-1){1'b1}}};
  localparam point_t POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};
  localparam rnd_t   CLIP_MAX  = RND_W'(POINT_MAX);
  localparam rnd_t   CLIP_MIN  = RND_W'(POINT_MIN);
  localparam usum_t  ROUND_HALF = U_W'(1) << (ROT_SHIFT - 1);

  typedef struct packed {
    point_t point_x;
    point_t point_y;
    point_t point_z;
    quat_t  quat_w;
    quat_t  quat_x;
    quat_t  quat_y;
    quat_t  quat_z;
  } qpr_in_t;

  typedef struct packed {
    point_t rotated_x;
    point_t rotated_y;
    point_t rotated_z;
    logic   saturated;
  } qpr_out_t;

  typedef struct packed {
    tsum_t t_w;
    tsum_t t_x;
    tsum_t t_y;
    tsum_t t_z;
    quat_t quat_w;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
  } qpr_tq_t;

  typedef struct packed {
    usum_t u_x;
    usum_t u_y;
    usum_t u_z;
  } qpr_u_t;

endpackage

// File: rtl/quaternion_point_rotation.sv
// Quaternion point rotation: rotated = vec(q * (0,p) * conj(q)).
// Input channel item_valid/item_ready/item carries one word with a signed
// 24-bit point and a Q2.14 quaternion; output channel
// result_valid/result_ready/result returns the rotated point in the point
// format plus a saturated flag. q is not normalized, so the result scales
// by |q|^2; the single rounding is to nearest, ties up, then clipping.
// Five register stages: product and sum registers for q*p, product and sum
// registers for the conj(q) product, and the round/clip output register.
// result_valid rises once the word reaches the round/clip output register.
// Throughput is one word per cycle while the output does not stall.
// Each stage holds its own valid bit and accepts when empty or when the
// stage after it moves, so bubbles close up under a stall. When the
// receiver holds result_ready low, the output word holds and the stages
// behind it fill; item_ready drops only when all five hold a word.
// Synchronous reset clears the valid bits; no word is lost or repeated.
module quaternion_point_rotation (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  qpr_pkg::qpr_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output qpr_pkg::qpr_out_t result
);
  import qpr_pkg::*;

  logic    tq_valid, tq_ready;
  qpr_tq_t tq_word;
  logic    u_valid, u_ready;
  qpr_u_t  u_word;

  qpr_qp_stage u_qp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .in_word   (item),
    .out_valid (tq_valid),
    .out_ready (tq_ready),
    .out_word  (tq_word)
  );

  qpr_rot_stage u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tq_valid),
    .in_ready  (tq_ready),
    .in_word   (tq_word),
    .out_valid (u_valid),
    .out_ready (u_ready),
    .out_word  (u_word)
  );

  qpr_round_clip u_clip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (u_valid),
    .in_ready  (u_ready),
    .in_word   (u_word),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_word  (result)
  );

endmodule

// File: rtl/qpr_qp_stage.sv
module qpr_qp_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  qpr_pkg::qpr_in_t in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output qpr_pkg::qpr_tq_t out_word
);
  import qpr_pkg::*;

  logic   prod_valid;
  logic   prod_ready;
  logic   sum_ready;
  prod1_t wx, wy, wz, xx, xy, xz, yx, yy, yz, zx, zy, zz;
  quat_t  qw, qx, qy, qz;

  assign sum_ready  = !out_valid || out_ready;
  assign prod_ready = !prod_valid || sum_ready;
  assign in_ready   = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= in_valid;
      end
      if (sum_ready) begin
        out_valid <= prod_valid;
      end
    end
  end

  // quaternion component times point coordinate
  always_ff @(posedge clk) begin
    if (prod_ready && in_valid) begin
      wx <= PROD1_W'(in_word.quat_w) * PROD1_W'(in_word.point_x);
      wy <= PROD1_W'(in_word.quat_w) * PROD1_W'(in_word.point_y);
      wz <= PROD1_W'(in_word.quat_w) * PROD1_W'(in_word.point_z);
      xx <= PROD1_W'(in_word.quat_x) * PROD1_W'(in_word.point_x);
      xy <= PROD1_W'(in_word.quat_x) * PROD1_W'(in_word.point_y);
      xz <= PROD1_W'(in_word.quat_x) * PROD1_W'(in_word.point_z);
      yx <= PROD1_W'(in_word.quat_y) * PROD1_W'(in_word.point_x);
      yy <= PROD1_W'(in_word.quat_y) * PROD1_W'(in_word.point_y);
      yz <= PROD1_W'(in_word.quat_y) * PROD1_W'(in_word.point_z);
      zx <= PROD1_W'(in_word.quat_z) * PROD1_W'(in_word.point_x);
      zy <= PROD1_W'(in_word.quat_z) * PROD1_W'(in_word.point_y);
      zz <= PROD1_W'(in_word.quat_z) * PROD1_W'(in_word.point_z);
      qw <= in_word.quat_w;
      qx <= in_word.quat_x;
      qy <= in_word.quat_y;
      qz <= in_word.quat_z;
    end
  end

  // hamilton product q * (0, p)
  always_ff @(posedge clk) begin
    if (sum_ready && prod_valid) begin
      out_word.t_w    <= -T_W'(xx) - T_W'(yy) - T_W'(zz);
      out_word.t_x    <= T_W'(wx) + T_W'(yz) - T_W'(zy);
      out_word.t_y    <= T_W'(wy) - T_W'(xz) + T_W'(zx);
      out_word.t_z    <= T_W'(wz) + T_W'(xy) - T_W'(yx);
      out_word.quat_w <= qw;
      out_word.quat_x <= qx;
      out_word.quat_y <= qy;
      out_word.quat_z <= qz;
    end
  end

endmodule

// File: rtl/qpr_rot_stage.sv
module qpr_rot_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  qpr_pkg::qpr_tq_t in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output qpr_pkg::qpr_u_t  out_word
);
  import qpr_pkg::*;

  logic   prod_valid;
  logic   prod_ready;
  logic   sum_ready;
  prod2_t x0, x1, x2, x3;
  prod2_t y0, y1, y2, y3;
  prod2_t z0, z1, z2, z3;

  assign sum_ready  = !out_valid || out_ready;
  assign prod_ready = !prod_valid || sum_ready;
  assign in_ready   = prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid <= in_valid;
      end
      if (sum_ready) begin
        out_valid <= prod_valid;
      end
    end
  end

  // terms of (q*p) * conj(q), vector part only
  always_ff @(posedge clk) begin
    if (prod_ready && in_valid) begin
      x0 <= PROD2_W'(in_word.t_w) * PROD2_W'(in_word.quat_x);
      x1 <= PROD2_W'(in_word.t_x) * PROD2_W'(in_word.quat_w);
      x2 <= PROD2_W'(in_word.t_y) * PROD2_W'(in_word.quat_z);
      x3 <= PROD2_W'(in_word.t_z) * PROD2_W'(in_word.quat_y);
      y0 <= PROD2_W'(in_word.t_w) * PROD2_W'(in_word.quat_y);
      y1 <= PROD2_W'(in_word.t_x) * PROD2_W'(in_word.quat_z);
      y2 <= PROD2_W'(in_word.t_y) * PROD2_W'(in_word.quat_w);
      y3 <= PROD2_W'(in_word.t_z) * PROD2_W'(in_word.quat_x);
      z0 <= PROD2_W'(in_word.t_w) * PROD2_W'(in_word.quat_z);
      z1 <= PROD2_W'(in_word.t_x) * PROD2_W'(in_word.quat_y);
      z2 <= PROD2_W'(in_word.t_y) * PROD2_W'(in_word.quat_x);
      z3 <= PROD2_W'(in_word.t_z) * PROD2_W'(in_word.quat_w);
    end
  end

  // sums carry the half lsb for rounding
  always_ff @(posedge clk) begin
    if (sum_ready && prod_valid) begin
      out_word.u_x <= ROUND_HALF - U_W'(x0) + U_W'(x1) - U_W'(x2) + U_W'(x3);
      out_word.u_y <= ROUND_HALF - U_W'(y0) + U_W'(y1) + U_W'(y2) - U_W'(y3);
      out_word.u_z <= ROUND_HALF - U_W'(z0) - U_W'(z1) + U_W'(z2) + U_W'(z3);
    end
  end

endmodule

// File: rtl/qpr_round_clip.sv
module qpr_round_clip (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  qpr_pkg::qpr_u_t   in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output qpr_pkg::qpr_out_t out_word
);
  import qpr_pkg::*;

  rnd_t rx, ry, rz;

  function automatic logic out_of_range(rnd_t r);
    return (r > CLIP_MAX) || (r < CLIP_MIN);
  endfunction

  function automatic point_t clamp(rnd_t r);
    point_t res;
    if (r > CLIP_MAX) begin
      res = POINT_MAX;
    end else if (r < CLIP_MIN) begin
      res = POINT_MIN;
    end else begin
      res = POINT_W'(r);
    end
    return res;
  endfunction

  // floor shift drops the fraction bits
  assign rx = RND_W'(in_word.u_x >>> ROT_SHIFT);
  assign ry = RND_W'(in_word.u_y >>> ROT_SHIFT);
  assign rz = RND_W'(in_word.u_z >>> ROT_SHIFT);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word.rotated_x <= clamp(rx);
      out_word.rotated_y <= clamp(ry);
      out_word.rotated_z <= clamp(rz);
      out_word.saturated <= out_of_range(rx) || out_of_range(ry) || out_of_range(rz);
    end
  end

endmodule

// File: rtl/qpr_checker.sv
module qpr_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input qpr_pkg::qpr_out_t result
);
  import qpr_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // a pending word is not dropped
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word dropped while stalled");

  // input backpressure only when the output is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("item_ready low without output stall");

  // a clipped word has a coordinate at a range end
  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      (result.rotated_x == POINT_MAX) || (result.rotated_x == POINT_MIN) ||
      (result.rotated_y == POINT_MAX) || (result.rotated_y == POINT_MIN) ||
      (result.rotated_z == POINT_MAX) || (result.rotated_z == POINT_MIN))
    else $error("saturated set with no clipped coordinate");

endmodule

bind quaternion_point_rotation qpr_checker u_qpr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
